### design/dmc_pkg.sv
// Shared types, codes and helper functions for the depth-first maze carver.
`default_nettype none

package dmc_pkg;

  // action codes of an input word
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // event codes of a result word
  localparam logic [2:0] EV_STARTED   = 3'd0;
  localparam logic [2:0] EV_CARVED    = 3'd1;
  localparam logic [2:0] EV_BACKTRACK = 3'd2;
  localparam logic [2:0] EV_FINISHED  = 3'd3;
  localparam logic [2:0] EV_READ      = 3'd4;

  // carve directions
  localparam logic [1:0] DIR_LEFT   = 2'd0;
  localparam logic [1:0] DIR_RIGHT  = 2'd1;
  localparam logic [1:0] DIR_TOP    = 2'd2;
  localparam logic [1:0] DIR_BOTTOM = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_LFSR_SEED = 1'b0;

  localparam logic [15:0] LFSR_MASK = 16'hB400;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] cell_col;
    logic [3:0] cell_row;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] out_col;
    logic [3:0] out_row;
    logic [1:0] carve_dir;
    logic       has_right_wall;
    logic       has_bottom_wall;
    logic       is_visited_out;
  } out_word_t;

  // commands from the controller to the datapath and output stage
  typedef struct packed {
    logic latch_in;
    logic sweep;
    logic start_fin;
    logic pop_load;
    logic nbr_step;
    logic backtrack;
    logic draw_step;
    logic carve;
    logic rd_issue;
    logic rd_cap;
    logic fin_res;
    logic emit;
  } ctl_t;

  // status from the datapath back to the controller
  typedef struct packed {
    logic stack_empty;
    logic sweep_last;
    logic nbr_last;
    logic mask_zero;
    logic draw_hit;
  } stat_t;

  // one Galois right shift of the direction LFSR
  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] r;
    r = s >> 1;
    if (s[0]) r = r ^ LFSR_MASK;
    return r;
  endfunction

endpackage

`default_nettype wire

### design/dmc_ctrl.sv
// Sequencing state machine for the maze carver.
`default_nettype none

module dmc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire logic [1:0]     action,
  input  wire logic           out_free,
  input  wire dmc_pkg::stat_t stat,
  output logic                cmd_stall,
  output dmc_pkg::ctl_t       ctl
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_SEED,
    S_STEP,
    S_NBR,
    S_DECIDE,
    S_DRAW,
    S_CARVE,
    S_RD,
    S_RDCAP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        ctl.sweep = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.latch_in = 1'b1;
          unique case (action)
            dmc_pkg::ACT_START: state_next = S_CLR;
            dmc_pkg::ACT_STEP:  state_next = S_STEP;
            dmc_pkg::ACT_READ:  state_next = S_RD;
            default:            state_next = S_IDLE;  // drop unused action
          endcase
        end
      end
      S_CLR: begin
        ctl.sweep = 1'b1;
        if (stat.sweep_last) state_next = S_SEED;
      end
      S_SEED: begin
        ctl.start_fin = 1'b1;
        state_next    = S_DONE;
      end
      S_STEP: begin
        if (stat.stack_empty) begin
          ctl.fin_res = 1'b1;
          state_next  = S_DONE;
        end else begin
          ctl.pop_load = 1'b1;
          state_next   = S_NBR;
        end
      end
      S_NBR: begin
        ctl.nbr_step = 1'b1;
        if (stat.nbr_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.mask_zero) begin
          ctl.backtrack = 1'b1;
          state_next    = S_DONE;
        end else begin
          state_next = S_DRAW;
        end
      end
      S_DRAW: begin
        ctl.draw_step = 1'b1;
        if (stat.draw_hit) state_next = S_CARVE;
      end
      S_CARVE: begin
        ctl.carve  = 1'b1;
        state_next = S_DONE;
      end
      S_RD: begin
        ctl.rd_issue = 1'b1;
        state_next   = S_RDCAP;
      end
      S_RDCAP: begin
        ctl.rd_cap = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  assign cmd_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### design/dmc_dp.sv
// Grid and stack memories, direction LFSR and result building for the maze carver.
`default_nettype none

module dmc_dp #(
  parameter int COLS        = 16,
  parameter int ROWS        = 16,
  parameter int STACK_DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dmc_pkg::ctl_t      ctl,
  input  wire dmc_pkg::in_word_t  cmd_word,
  input  wire logic [15:0]        seed,
  output dmc_pkg::stat_t          stat,
  output dmc_pkg::out_word_t      res
);

  localparam int CW     = $clog2(COLS);
  localparam int RW     = $clog2(ROWS);
  localparam int GAW    = CW + RW;
  localparam int GDEPTH = 1 << GAW;
  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int CNTW   = $clog2(STACK_DEPTH + 1);

  function automatic logic [CW-1:0] step_col(input logic [CW-1:0] c, input logic [1:0] d);
    logic [CW-1:0] r;
    r = c;
    if (d == dmc_pkg::DIR_LEFT) r = c - CW'(1);
    else if (d == dmc_pkg::DIR_RIGHT) r = c + CW'(1);
    return r;
  endfunction

  function automatic logic [RW-1:0] step_row(input logic [RW-1:0] rr, input logic [1:0] d);
    logic [RW-1:0] r;
    r = rr;
    if (d == dmc_pkg::DIR_TOP) r = rr - RW'(1);
    else if (d == dmc_pkg::DIR_BOTTOM) r = rr + RW'(1);
    return r;
  endfunction

  // cell storage, addressed by {row, col}
  logic vis_mem [GDEPTH];
  logic rw_mem  [GDEPTH];
  logic bw_mem  [GDEPTH];
  logic [GAW-1:0] stk_mem [STACK_DEPTH];

  dmc_pkg::in_word_t  item;
  dmc_pkg::out_word_t res_next;
  logic [GAW-1:0]     sweep;
  logic [CW-1:0]      cur_col;
  logic [RW-1:0]      cur_row;
  logic [2:0]         nbr_k;
  logic [3:0]         mask;
  logic [15:0]        draw_cnt;
  logic [1:0]         sel_dir;
  logic [15:0]        lfsr;
  logic [CNTW-1:0]    count;

  logic           vis_q, rw_q, bw_q;
  logic [GAW-1:0] stk_q;

  logic [CW-1:0]   item_col, probe_col, car_col;
  logic [RW-1:0]   item_row, probe_row, car_row;
  logic            in_grid;
  logic [3:0]      inb;
  logic [1:0]      k_prev;
  logic [GAW-1:0]  raddr;
  logic [CNTW-1:0] top_cnt;
  logic [SAW-1:0]  top_addr;
  logic            full;
  logic [15:0]     lfsr2;
  logic [1:0]      draw_dir, first_dir;
  logic            hit;

  logic           vis_we, rw_we, bw_we, stk_we;
  logic [GAW-1:0] vis_waddr, rw_waddr, bw_waddr, stk_wdata;
  logic [SAW-1:0] stk_waddr;
  logic           vis_wdata;

  assign item_col = CW'(item.cell_col);
  assign item_row = RW'(item.cell_row);
  assign in_grid  = (32'(item.cell_col) < 32'(COLS)) && (32'(item.cell_row) < 32'(ROWS));

  assign inb[0] = (cur_col != '0);
  assign inb[1] = (cur_col != CW'(COLS - 1));
  assign inb[2] = (cur_row != '0);
  assign inb[3] = (cur_row != RW'(ROWS - 1));

  assign probe_col = step_col(cur_col, nbr_k[1:0]);
  assign probe_row = step_row(cur_row, nbr_k[1:0]);
  assign k_prev    = nbr_k[1:0] - 2'd1;
  assign car_col   = step_col(cur_col, sel_dir);
  assign car_row   = step_row(cur_row, sel_dir);

  assign raddr    = ctl.rd_issue ? {item_row, item_col} : {probe_row, probe_col};
  assign top_cnt  = count - CNTW'(1);
  assign top_addr = top_cnt[SAW-1:0];
  assign full     = (count == CNTW'(STACK_DEPTH));

  assign lfsr2    = dmc_pkg::lfsr_step(dmc_pkg::lfsr_step(lfsr));
  assign draw_dir = lfsr2[1:0];
  assign hit      = mask[draw_dir];

  always_comb begin
    priority if (mask[0]) first_dir = dmc_pkg::DIR_LEFT;
    else if (mask[1])     first_dir = dmc_pkg::DIR_RIGHT;
    else if (mask[2])     first_dir = dmc_pkg::DIR_TOP;
    else                  first_dir = dmc_pkg::DIR_BOTTOM;
  end

  // write port selection; a sweep restores unvisited with both walls up
  always_comb begin
    vis_we    = ctl.sweep || (ctl.start_fin && in_grid) || ctl.carve;
    vis_wdata = !ctl.sweep;
    priority if (ctl.sweep) vis_waddr = sweep;
    else if (ctl.start_fin) vis_waddr = {item_row, item_col};
    else                    vis_waddr = {car_row, car_col};

    rw_we = ctl.sweep || (ctl.carve &&
            (sel_dir == dmc_pkg::DIR_LEFT || sel_dir == dmc_pkg::DIR_RIGHT));
    priority if (ctl.sweep)                  rw_waddr = sweep;
    else if (sel_dir == dmc_pkg::DIR_LEFT)   rw_waddr = {car_row, car_col};
    else                                     rw_waddr = {cur_row, cur_col};

    bw_we = ctl.sweep || (ctl.carve &&
            (sel_dir == dmc_pkg::DIR_TOP || sel_dir == dmc_pkg::DIR_BOTTOM));
    priority if (ctl.sweep)                  bw_waddr = sweep;
    else if (sel_dir == dmc_pkg::DIR_TOP)    bw_waddr = {car_row, car_col};
    else                                     bw_waddr = {cur_row, cur_col};

    stk_we    = (ctl.start_fin && in_grid) || (ctl.carve && !full);
    stk_waddr = ctl.start_fin ? '0 : count[SAW-1:0];
    stk_wdata = ctl.start_fin ? {item_row, item_col} : {car_row, car_col};
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    vis_q <= vis_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rw_we) rw_mem[rw_waddr] <= ctl.sweep;
    rw_q <= rw_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (bw_we) bw_mem[bw_waddr] <= ctl.sweep;
    bw_q <= bw_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_q <= stk_mem[top_addr];
  end

  always_comb begin
    res_next = res;
    priority if (ctl.start_fin) begin
      res_next           = '0;
      res_next.event_res = dmc_pkg::EV_STARTED;
      res_next.out_col   = item.cell_col;
      res_next.out_row   = item.cell_row;
    end else if (ctl.fin_res) begin
      res_next           = '0;
      res_next.event_res = dmc_pkg::EV_FINISHED;
    end else if (ctl.backtrack) begin
      res_next           = '0;
      res_next.event_res = dmc_pkg::EV_BACKTRACK;
      res_next.out_col   = 4'(cur_col);
      res_next.out_row   = 4'(cur_row);
    end else if (ctl.carve) begin
      res_next           = '0;
      res_next.event_res = dmc_pkg::EV_CARVED;
      res_next.out_col   = 4'(car_col);
      res_next.out_row   = 4'(car_row);
      res_next.carve_dir = sel_dir;
    end else if (ctl.rd_cap) begin
      res_next                 = '0;
      res_next.event_res       = dmc_pkg::EV_READ;
      res_next.out_col         = item.cell_col;
      res_next.out_row         = item.cell_row;
      res_next.has_right_wall  = in_grid && rw_q;
      res_next.has_bottom_wall = in_grid && bw_q;
      res_next.is_visited_out  = in_grid && vis_q;
    end else begin
      res_next = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      count <= '0;
      lfsr  <= 16'd1;
      nbr_k <= '0;
    end else begin
      if (ctl.sweep) sweep <= sweep + GAW'(1);
      if (ctl.start_fin) begin
        count <= in_grid ? CNTW'(1) : '0;
        lfsr  <= (seed == '0) ? 16'd1 : seed;
      end else if (ctl.backtrack) begin
        count <= count - CNTW'(1);
      end else if (ctl.carve && !full) begin
        count <= count + CNTW'(1);
      end else if (ctl.draw_step) begin
        lfsr <= lfsr2;
      end
      if (ctl.pop_load) nbr_k <= '0;
      else if (ctl.nbr_step) nbr_k <= nbr_k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) item <= cmd_word;
    if (ctl.pop_load) begin
      cur_col  <= stk_q[CW-1:0];
      cur_row  <= stk_q[GAW-1:CW];
      mask     <= '0;
      draw_cnt <= '0;
    end else begin
      // capture the visited bit of the neighbor probed last cycle
      if (ctl.nbr_step && nbr_k != 3'd0) mask[k_prev] <= inb[k_prev] && !vis_q;
      if (ctl.draw_step) begin
        draw_cnt <= draw_cnt + 16'd1;
        sel_dir  <= hit ? draw_dir : first_dir;
      end
    end
    res <= res_next;
  end

  assign stat.stack_empty = (count == '0);
  assign stat.sweep_last  = &sweep;
  assign stat.nbr_last    = (nbr_k == 3'd4);
  assign stat.mask_zero   = (mask == '0);
  // give up on the draw after the full LFSR period and take the first open side
  assign stat.draw_hit    = hit || (&draw_cnt);

endmodule

`default_nettype wire

### design/dfs_maze_carver.sv
// Top level of the depth-first maze carver: config register, output register, glue.
`default_nettype none

// Randomized depth-first maze carver over a COLS by ROWS grid, one item in flight
// at a time. After reset the block sweeps its cell memories once before the first
// word is accepted. A start repeats that sweep. A step reads the top of the stack,
// then probes the four neighbors through the single read port of the grid memory,
// and either backtracks or draws from the LFSR until it hits an open side and
// carves; a step on an empty stack finishes. A finished result sits in an output
// register, so the next word is accepted while it waits. lfsr_seed at byte
// address 0 is read only by the next start.
module dfs_maze_carver #(
  parameter int COLS        = 16,
  parameter int ROWS        = 16,
  parameter int STACK_DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire dmc_pkg::in_word_t  cmd_word,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output dmc_pkg::out_word_t      res_word,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  dmc_pkg::ctl_t      ctl;
  dmc_pkg::stat_t     stat;
  dmc_pkg::out_word_t dp_res;
  logic [15:0]        seed;
  logic               out_free;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == dmc_pkg::REG_LFSR_SEED) ? 32'(seed) : '0;
  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 16'd1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == dmc_pkg::REG_LFSR_SEED) begin
      seed <= pwdata[15:0];
    end
  end

  // output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) res_word <= dp_res;
  end

  dmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .action    (cmd_word.action),
    .out_free  (out_free),
    .stat      (stat),
    .cmd_stall (cmd_stall),
    .ctl       (ctl)
  );

  dmc_dp #(
    .COLS        (COLS),
    .ROWS        (ROWS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cmd_word (cmd_word),
    .seed     (seed),
    .stat     (stat),
    .res      (dp_res)
  );

`ifndef SYNTHESIS
  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!res_valid || !res_stall))
    else $error("result loaded over a word still waiting");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !cmd_stall)
    else $error("controller not idle after handing over a result");

  a_flags_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.event_res != dmc_pkg::EV_READ) |->
      (!res_word.has_right_wall && !res_word.has_bottom_wall && !res_word.is_visited_out))
    else $error("cell flags set on a non-read result");

  a_finished_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.event_res == dmc_pkg::EV_FINISHED) |->
      (res_word.out_col == '0 && res_word.out_row == '0 && res_word.carve_dir == '0))
    else $error("finished result carries a cell");
`endif

endmodule

`default_nettype wire

### tb/sv/dfs_maze_carver_tb.sv
// Self-checking testbench for the depth-first maze carver: random stimulus, own predictor.
`timescale 1ns / 100ps

module dfs_maze_carver_tb;

  localparam int NCOLS = 16;
  localparam int NROWS = 16;
  localparam int NCELLS = NCOLS * NROWS;
  localparam int PATH_DEPTH = 256;
  localparam int DRAW_LIMIT = 65536;
  localparam int SETTLE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [1:0] ACT_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  dmc_pkg::in_word_t cmd_word = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  dmc_pkg::out_word_t res_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor state
  bit cell_seen [NCELLS];
  bit wall_right [NCELLS];
  bit wall_below [NCELLS];
  int path_stack [PATH_DEPTH];
  int path_depth;
  logic [15:0] dir_shift;
  logic [15:0] seed_val;

  dmc_pkg::in_word_t pending_q[$];
  dmc_pkg::out_word_t maze_events_q[$];
  int fail_cnt = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  bit cmd_fired = 1'b0;
  bit res_fired;
  bit produced;
  dmc_pkg::out_word_t want;

  dfs_maze_carver #(
    .COLS(NCOLS),
    .ROWS(NROWS),
    .STACK_DEPTH(PATH_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_word(cmd_word),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_word(res_word),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // true if dir from (c,r) lands on an unvisited cell inside the grid
  function automatic bit nbr_open(input int c, input int r, input logic [1:0] dir,
                                  output int nidx);
    int nc, nr;
    nc = c;
    nr = r;
    nidx = 0;
    case (dir)
      dmc_pkg::DIR_LEFT: begin
        if (c == 0) return 1'b0;
        nc = c - 1;
      end
      dmc_pkg::DIR_RIGHT: begin
        if (c + 1 >= NCOLS) return 1'b0;
        nc = c + 1;
      end
      dmc_pkg::DIR_TOP: begin
        if (r == 0) return 1'b0;
        nr = r - 1;
      end
      default: begin
        if (r + 1 >= NROWS) return 1'b0;
        nr = r + 1;
      end
    endcase
    nidx = nr * NCOLS + nc;
    return !cell_seen[nidx];
  endfunction

  task automatic wipe_grid;
    for (int i = 0; i < NCELLS; i++) begin
      cell_seen[i] = 1'b0;
      wall_right[i] = 1'b1;
      wall_below[i] = 1'b1;
    end
  endtask

  task automatic maze_predict(input dmc_pkg::in_word_t w, output bit has_res,
                              output dmc_pkg::out_word_t res);
    int c, r, idx, cur, cc, cr, nidx, k;
    bit any, found;
    logic [1:0] dir;
    res = '0;
    has_res = 1'b1;
    c = int'(w.cell_col);
    r = int'(w.cell_row);
    nidx = 0;
    case (w.action)
      dmc_pkg::ACT_START: begin
        wipe_grid();
        path_depth = 0;
        // a zero seed would lock the shifter
        dir_shift = (seed_val == 16'd0) ? 16'd1 : seed_val;
        if (c < NCOLS && r < NROWS) begin
          idx = r * NCOLS + c;
          cell_seen[idx] = 1'b1;
          path_stack[0] = idx;
          path_depth = 1;
        end
        res.event_res = dmc_pkg::EV_STARTED;
        res.out_col = w.cell_col;
        res.out_row = w.cell_row;
      end
      dmc_pkg::ACT_READ: begin
        res.event_res = dmc_pkg::EV_READ;
        res.out_col = w.cell_col;
        res.out_row = w.cell_row;
        if (c < NCOLS && r < NROWS) begin
          idx = r * NCOLS + c;
          res.has_right_wall = wall_right[idx];
          res.has_bottom_wall = wall_below[idx];
          res.is_visited_out = cell_seen[idx];
        end
      end
      dmc_pkg::ACT_STEP: begin
        if (path_depth == 0) begin
          res.event_res = dmc_pkg::EV_FINISHED;
        end else begin
          cur = path_stack[path_depth - 1];
          cc = cur % NCOLS;
          cr = cur / NCOLS;
          any = 1'b0;
          for (k = 0; k < 4; k++)
            if (nbr_open(cc, cr, k[1:0], nidx)) any = 1'b1;
          if (!any) begin
            path_depth--;
            res.event_res = dmc_pkg::EV_BACKTRACK;
            res.out_col = cc[3:0];
            res.out_row = cr[3:0];
          end else begin
            found = 1'b0;
            dir = dmc_pkg::DIR_LEFT;
            for (k = 0; k < DRAW_LIMIT && !found; k++) begin
              repeat (2)
                dir_shift = (dir_shift >> 1) ^
                            (dir_shift[0] ? dmc_pkg::LFSR_MASK : 16'h0000);
              dir = dir_shift[1:0];
              found = nbr_open(cc, cr, dir, nidx);
            end
            for (k = 0; k < 4 && !found; k++) begin
              dir = k[1:0];
              found = nbr_open(cc, cr, dir, nidx);
            end
            case (dir)
              dmc_pkg::DIR_LEFT: wall_right[nidx] = 1'b0;
              dmc_pkg::DIR_RIGHT: wall_right[cur] = 1'b0;
              dmc_pkg::DIR_TOP: wall_below[nidx] = 1'b0;
              default: wall_below[cur] = 1'b0;
            endcase
            cell_seen[nidx] = 1'b1;
            // a full stack still carves, it just drops the push
            if (path_depth < PATH_DEPTH) begin
              path_stack[path_depth] = nidx;
              path_depth++;
            end
            res.event_res = dmc_pkg::EV_CARVED;
            res.out_col = 4'(nidx % NCOLS);
            res.out_row = 4'(nidx / NCOLS);
            res.carve_dir = dir;
          end
        end
      end
      default: has_res = 1'b0;
    endcase
  endtask

  task automatic log_fail(input string why, input dmc_pkg::out_word_t e,
                          input dmc_pkg::out_word_t a);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $write("%s: exp ev=%0d col=%0d row=%0d dir=%0d rw=%0b bw=%0b vis=%0b",
             why, e.event_res, e.out_col, e.out_row, e.carve_dir, e.has_right_wall,
             e.has_bottom_wall, e.is_visited_out);
      $display(" | got ev=%0d col=%0d row=%0d dir=%0d rw=%0b bw=%0b vis=%0b",
               a.event_res, a.out_col, a.out_row, a.carve_dir, a.has_right_wall,
               a.has_bottom_wall, a.is_visited_out);
    end
  endtask

  // send side: a new word goes out only once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_gap = 0;
    end else if (!cmd_valid || cmd_fired) begin
      if (send_gap > 0) begin
        cmd_valid <= 1'b0;
        send_gap--;
      end else if (pending_q.size() != 0) begin
        cmd_word <= pending_q.pop_front();
        cmd_valid <= 1'b1;
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        send_gap = pick_gap(send_burst);
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // receive side: random stalls with quiet stretches
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      res_stall <= 1'b0;
      if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
      stall_left = pick_gap(recv_burst);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cmd_fired = 1'b0;
      idle_cycles = 0;
    end else begin
      cmd_fired = cmd_valid && !cmd_stall;
      res_fired = res_valid && !res_stall;
      if (cmd_fired) begin
        maze_predict(cmd_word, produced, want);
        if (produced) maze_events_q.push_back(want);
      end
      if (res_fired) begin
        if (maze_events_q.size() == 0) begin
          log_fail("result with nothing pending", '0, res_word);
        end else begin
          want = maze_events_q.pop_front();
          if (res_word.event_res !== want.event_res || res_word.out_col !== want.out_col ||
              res_word.out_row !== want.out_row || res_word.carve_dir !== want.carve_dir ||
              res_word.has_right_wall !== want.has_right_wall ||
              res_word.has_bottom_wall !== want.has_bottom_wall ||
              res_word.is_visited_out !== want.is_visited_out)
            log_fail("result mismatch", want, res_word);
        end
      end
      if (cmd_fired || res_fired) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("dfs_maze_carver test failed");
          $finish;
        end
      end
    end
  end

  task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {dmc_pkg::REG_LFSR_SEED, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_seed_reg;
    logic [31:0] rd;
    apb_xfer(1'b0, 32'h0, rd);
    if (rd[15:0] !== seed_val) begin
      fail_cnt++;
      if (fail_cnt <= 10) $display("lfsr_seed readback: exp %h got %h", seed_val, rd[15:0]);
    end
  endtask

  task automatic seed_load(input logic [31:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, value, rd);
    seed_val = value[15:0];
    check_seed_reg();
    @(posedge clk);
  endtask

  task automatic queue_word(input logic [1:0] act, input int col, input int row);
    dmc_pkg::in_word_t w;
    w.action = act;
    w.cell_col = col[3:0];
    w.cell_row = row[3:0];
    pending_q.push_back(w);
  endtask

  // random words until step_goal steps are queued; the rest are steps
  task automatic queue_walk(input int step_goal, input int p_start, input int p_read,
                            input int p_noise);
    int steps, r;
    steps = 0;
    while (steps < step_goal) begin
      r = $urandom_range(0, 99);
      if (r < p_start)
        queue_word(dmc_pkg::ACT_START, $urandom_range(0, 15), $urandom_range(0, 15));
      else if (r < p_start + p_read)
        queue_word(dmc_pkg::ACT_READ, $urandom_range(0, 15), $urandom_range(0, 15));
      else if (r < p_start + p_read + p_noise)
        queue_word(ACT_NONE, $urandom_range(0, 15), $urandom_range(0, 15));
      else begin
        queue_word(dmc_pkg::ACT_STEP, $urandom_range(0, 15), $urandom_range(0, 15));
        steps++;
      end
    end
  endtask

  // hold until every word is taken and answered, then let the block go idle
  task automatic drain_block;
    do begin
      @(posedge clk);
      #1;
    end while (pending_q.size() != 0 || cmd_valid || maze_events_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    wipe_grid();
    path_depth = 0;
    dir_shift = 16'd1;
    seed_val = 16'd1;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    check_seed_reg();

    // directed: fresh grid, empty stack, corner starts, ignored action
    queue_word(ACT_NONE, 15, 15);
    queue_word(dmc_pkg::ACT_READ, 0, 0);
    queue_word(dmc_pkg::ACT_READ, 15, 15);
    queue_word(dmc_pkg::ACT_STEP, 0, 0);
    queue_word(dmc_pkg::ACT_START, 0, 0);
    repeat (4) queue_word(dmc_pkg::ACT_STEP, 0, 0);
    queue_word(dmc_pkg::ACT_READ, 0, 0);
    queue_word(dmc_pkg::ACT_READ, 1, 0);
    queue_word(ACT_NONE, 0, 0);
    queue_word(dmc_pkg::ACT_START, 15, 15);
    repeat (3) queue_word(dmc_pkg::ACT_STEP, 15, 15);
    queue_word(dmc_pkg::ACT_READ, 15, 15);
    queue_word(dmc_pkg::ACT_START, 15, 0);
    repeat (2) queue_word(dmc_pkg::ACT_STEP, 0, 15);
    queue_word(dmc_pkg::ACT_START, 0, 15);
    repeat (2) queue_word(dmc_pkg::ACT_STEP, 15, 0);
    queue_word(dmc_pkg::ACT_READ, 0, 15);
    drain_block();

    // zero seed: carve one full maze through to finished
    seed_load(32'h0000_0000);
    queue_word(dmc_pkg::ACT_START, $urandom_range(0, 15), $urandom_range(0, 15));
    queue_walk(516, 0, 8, 3);
    drain_block();

    // all-ones seed: several partial mazes
    seed_load(32'h0000_FFFF);
    repeat (6) begin
      queue_word(dmc_pkg::ACT_START, $urandom_range(0, 15), $urandom_range(0, 15));
      queue_walk($urandom_range(8, 60), 0, 12, 4);
    end
    drain_block();

    // random seed with junk in the upper bits, broken sequences
    seed_load({16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65534))});
    queue_word(dmc_pkg::ACT_START, $urandom_range(0, 15), $urandom_range(0, 15));
    queue_walk(170, 10, 22, 10);
    drain_block();

    if (fail_cnt == 0 && maze_events_q.size() == 0)
      $display("dfs_maze_carver test passed");
    else
      $display("dfs_maze_carver test failed");
    $finish;
  end

endmodule
